### hdl/tfrd_pkg.sv
// ----------------------------------------------------------------------------
// Tagged field record decoder package
// Transfer types, field tag codes and result kind codes shared by the decoder
// modules.
// ----------------------------------------------------------------------------
package tfrd_pkg;

    localparam int FIELD_LIMIT_W = 7;
    localparam logic [FIELD_LIMIT_W-1:0] FIELD_LIMIT_RESET = 7'd64;

    localparam logic [7:0] TAG_NULL   = 8'd0;
    localparam logic [7:0] TAG_INT    = 8'd1;
    localparam logic [7:0] TAG_DOUBLE = 8'd2;
    localparam logic [7:0] TAG_STRING = 8'd3;
    localparam logic [7:0] TAG_BOOL   = 8'd4;

    localparam logic [2:0] KIND_NULL   = 3'd0;
    localparam logic [2:0] KIND_INT    = 3'd1;
    localparam logic [2:0] KIND_DOUBLE = 3'd2;
    localparam logic [2:0] KIND_HEADER = 3'd3;
    localparam logic [2:0] KIND_BOOL   = 3'd4;
    localparam logic [2:0] KIND_STRBYTE = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;
    localparam logic [2:0] KIND_TRUNC  = 3'd7;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       last_byte;
    } tfrd_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic [5:0]  field_index;
        logic        record_end;
    } tfrd_out_t;

endpackage

### hdl/tfrd_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted record byte until the parser consumes it.
// ----------------------------------------------------------------------------
module tfrd_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tfrd_pkg::tfrd_in_t s_data,
    input  logic              take,
    output logic              in_valid,
    output tfrd_pkg::tfrd_in_t in_item
);

    logic               valid_reg;
    tfrd_pkg::tfrd_in_t item_reg;

    assign s_ready  = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

endmodule

### hdl/tfrd_core.sv
// ----------------------------------------------------------------------------
// Record parser
// Keeps the field phase, byte count, assembled value and field count, and
// works out the result that one record byte causes.
// ----------------------------------------------------------------------------
module tfrd_core #(
    parameter int MAX_FIELDS = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 take,
    input  tfrd_pkg::tfrd_in_t                   in_item,
    input  logic [tfrd_pkg::FIELD_LIMIT_W-1:0]   field_limit,
    output logic                                 res_valid,
    output tfrd_pkg::tfrd_out_t                  res_item
);

    localparam int FS_W  = $clog2(MAX_FIELDS + 1);
    localparam int LIM_W = (FS_W > tfrd_pkg::FIELD_LIMIT_W) ? FS_W : tfrd_pkg::FIELD_LIMIT_W;

    localparam logic [2:0] PH_TAG  = 3'd0;
    localparam logic [2:0] PH_INT  = 3'd1;
    localparam logic [2:0] PH_DBL  = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_BOOL = 3'd4;
    localparam logic [2:0] PH_STR  = 3'd5;

    logic [2:0]      phase_reg, phase_next;
    logic [31:0]     remain_reg, remain_next;
    logic [63:0]     asm_reg, asm_next;
    logic [FS_W-1:0] seen_reg, seen_next;

    logic [LIM_W-1:0] limit_ext;
    logic [LIM_W-1:0] max_ext;
    logic [LIM_W-1:0] seen_ext;
    logic             at_limit;
    logic [2:0]       pos;
    logic [63:0]      asm_new;
    logic [31:0]      remain_dec;
    logic [31:0]      missing;
    logic             have;
    logic [2:0]       kind;
    logic [63:0]      value;
    logic [5:0]       index;
    logic             rec_end;

    assign limit_ext = LIM_W'(field_limit);
    assign max_ext   = LIM_W'(MAX_FIELDS);
    assign seen_ext  = LIM_W'(seen_reg);
    assign at_limit  = (limit_ext < max_ext) ? (seen_ext >= limit_ext) : (seen_ext >= max_ext);

    assign pos        = ((phase_reg == PH_LEN) ? 3'd4 : 3'd0) - remain_reg[2:0];
    assign asm_new    = asm_reg | (64'(in_item.record_byte) << {pos, 3'b000});
    assign remain_dec = (remain_reg != 32'd0) ? remain_reg - 32'd1 : 32'd0;

    always_comb begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        asm_next    = asm_reg;
        seen_next   = seen_reg;
        have        = 1'b0;
        kind        = tfrd_pkg::KIND_NULL;
        value       = 64'd0;
        index       = 6'(seen_reg);
        rec_end     = 1'b0;
        missing     = 32'd0;

        case (phase_reg)
            PH_TAG: begin
                if (!at_limit) begin
                    case (in_item.record_byte)
                        tfrd_pkg::TAG_NULL: begin
                            have      = 1'b1;
                            seen_next = seen_reg + FS_W'(1);
                        end
                        tfrd_pkg::TAG_INT, tfrd_pkg::TAG_DOUBLE: begin
                            phase_next  = (in_item.record_byte == tfrd_pkg::TAG_INT)
                                          ? PH_INT : PH_DBL;
                            remain_next = 32'd8;
                            asm_next    = 64'd0;
                            missing     = 32'd8;
                        end
                        tfrd_pkg::TAG_STRING: begin
                            phase_next  = PH_LEN;
                            remain_next = 32'd4;
                            asm_next    = 64'd0;
                            missing     = 32'd4;
                        end
                        tfrd_pkg::TAG_BOOL: begin
                            phase_next = PH_BOOL;
                            missing    = 32'd1;
                        end
                        default: begin
                            seen_next = seen_reg + FS_W'(1);
                        end
                    endcase
                end
            end
            PH_INT, PH_DBL, PH_LEN: begin
                asm_next    = asm_new;
                remain_next = remain_dec;
                if (remain_dec != 32'd0) begin
                    missing = remain_dec;
                end else if (phase_reg == PH_LEN) begin
                    have  = 1'b1;
                    kind  = tfrd_pkg::KIND_HEADER;
                    value = 64'(asm_new[31:0]);
                    if (asm_new[31:0] == 32'd0) begin
                        seen_next  = seen_reg + FS_W'(1);
                        phase_next = PH_TAG;
                    end else begin
                        remain_next = asm_new[31:0];
                        phase_next  = PH_STR;
                        missing     = asm_new[31:0];
                    end
                end else begin
                    have       = 1'b1;
                    kind       = (phase_reg == PH_INT) ? tfrd_pkg::KIND_INT
                                                       : tfrd_pkg::KIND_DOUBLE;
                    value      = asm_new;
                    seen_next  = seen_reg + FS_W'(1);
                    phase_next = PH_TAG;
                end
            end
            PH_BOOL: begin
                have       = 1'b1;
                kind       = tfrd_pkg::KIND_BOOL;
                value      = 64'(in_item.record_byte != 8'd0);
                seen_next  = seen_reg + FS_W'(1);
                phase_next = PH_TAG;
            end
            PH_STR: begin
                have        = 1'b1;
                kind        = tfrd_pkg::KIND_STRBYTE;
                value       = 64'(in_item.record_byte);
                remain_next = remain_dec;
                if (remain_dec == 32'd0) begin
                    seen_next  = seen_reg + FS_W'(1);
                    phase_next = PH_TAG;
                end else begin
                    missing = remain_dec;
                end
            end
            default: begin
                phase_next = PH_TAG;
            end
        endcase

        if (in_item.last_byte) begin
            rec_end = 1'b1;
            if (missing != 32'd0) begin
                kind  = tfrd_pkg::KIND_TRUNC;
                value = 64'(missing);
            end else if (!have) begin
                kind  = tfrd_pkg::KIND_END;
                value = 64'(seen_next);
                index = 6'd0;
            end
            have        = 1'b1;
            phase_next  = PH_TAG;
            remain_next = 32'd0;
            asm_next    = 64'd0;
            seen_next   = '0;
        end
    end

    assign res_valid            = take && have;
    assign res_item.kind        = kind;
    assign res_item.value       = value;
    assign res_item.field_index = index;
    assign res_item.record_end  = rec_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TAG;
            remain_reg <= 32'd0;
            asm_reg    <= 64'd0;
            seen_reg   <= '0;
        end else if (take) begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            asm_reg    <= asm_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

### hdl/tfrd_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module tfrd_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  tfrd_pkg::tfrd_out_t res_item,
    output logic                space,
    output logic                m_valid,
    input  logic                m_ready,
    output tfrd_pkg::tfrd_out_t m_data
);

    logic                valid_reg;
    tfrd_pkg::tfrd_out_t data_reg;

    assign space   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_item;
        end
    end

endmodule

### hdl/tagged_field_record_decoder.sv
// ----------------------------------------------------------------------------
// Tagged field record decoder
// Parses a byte stream of tag-length-value fields into typed results.
// ----------------------------------------------------------------------------
// The decoder takes one record byte per cycle when not stalled. Each byte is
// held in an input register and parsed by combinational logic once the result
// register has space; any result that the byte gives is loaded into the result
// register at the end of that cycle. A byte can be accepted in
// every cycle; the only thing that stops input is a result that the downstream
// side has not yet taken while the input register also holds a byte. Integers
// and double bits give one result after their eighth payload byte, strings give
// a header result and one result per data byte, and the last byte of a record
// always gives a result marked as the record end. The field limit register may
// only be written while no bytes are in flight.
module tagged_field_record_decoder #(
    parameter int MAX_FIELDS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tfrd_pkg::tfrd_in_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tfrd_pkg::tfrd_out_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tfrd_pkg::FIELD_LIMIT_W-1:0] cfg_data
);

    logic [tfrd_pkg::FIELD_LIMIT_W-1:0] field_limit_reg;
    logic                               in_valid;
    tfrd_pkg::tfrd_in_t                 in_item;
    logic                               take;
    logic                               space;
    logic                               res_valid;
    tfrd_pkg::tfrd_out_t                res_item;

    assign cfg_ready = 1'b1;
    assign take      = in_valid && space;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_limit_reg <= tfrd_pkg::FIELD_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            field_limit_reg <= cfg_data;
        end
    end

    tfrd_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .take     (take),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    tfrd_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .in_item     (in_item),
        .field_limit (field_limit_reg),
        .res_valid   (res_valid),
        .res_item    (res_item)
    );

    tfrd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res_item (res_item),
        .space    (space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_end_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == tfrd_pkg::KIND_END)
            |-> (m_data.record_end && m_data.field_index == 6'd0))
        else $error("end result without record end or with a nonzero field index");

    a_trunc_missing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == tfrd_pkg::KIND_TRUNC)
            |-> (m_data.record_end && m_data.value != 64'd0))
        else $error("truncation result without record end or missing bytes");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while both registers are held");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && in_item.last_byte) |=> m_valid && m_data.record_end)
        else $error("last byte of a record gave no closing result");

endmodule
